// ===== rtl/szs_pkg.sv =====
// ----------------------------------------------------------------------------
// szs_pkg
// Shared widths, op codes, status codes and control structs for the sample
// statistics block.
// ----------------------------------------------------------------------------
package szs_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int CNT_W      = 13;
    localparam int SUM_W      = 36;
    // a full set of extreme samples sums squares up to 2^58
    localparam int SQ_W       = 59;
    localparam int WIDE_W     = 72;
    localparam int ROOT_W     = 36;
    localparam int DEV_W      = 23;
    localparam int Z_W        = 24;
    localparam int STAT_W     = 2;
    localparam int DIVN_W     = 41;
    localparam int STEP_W     = 6;
    localparam int OUT_DATA_W = 80;

    localparam int MUL_STEPS  = 36;
    localparam int SQRT_STEPS = 36;
    localparam int DIV_STEPS  = 41;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO_DEV = 2'd1;
    localparam logic [STAT_W-1:0] STAT_CAPACITY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SAT      = 2'd3;

    localparam logic [DIVN_W-1:0] Z_POS_LIMIT = 41'h7FFFFF;
    localparam logic [DIVN_W-1:0] Z_NEG_LIMIT = 41'h800000;
    localparam logic [DEV_W-1:0]  DEV_MAX     = 23'h7FFFFF;

    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_MA_INIT = 4'd1;
    localparam logic [3:0] OP_MUL     = 4'd2;
    localparam logic [3:0] OP_MB_INIT = 4'd3;
    localparam logic [3:0] OP_SQ_INIT = 4'd4;
    localparam logic [3:0] OP_SQRT    = 4'd5;
    localparam logic [3:0] OP_DM_INIT = 4'd6;
    localparam logic [3:0] OP_DIV     = 4'd7;
    localparam logic [3:0] OP_DD_INIT = 4'd8;
    localparam logic [3:0] OP_DZ_INIT = 4'd9;

    typedef struct packed {
        logic [3:0] op;
        logic       accept;
        logic       out_load;
    } szs_cmd_t;

    typedef struct packed {
        logic dev_zero;
        logic out_free;
    } szs_stat_t;

endpackage

// ===== rtl/sample_zscore_stats.sv =====
// ----------------------------------------------------------------------------
// sample_zscore_stats
// Throughput: one beat per cycle inside a set. After the last beat of a set
// the input stalls while the 36-step multiply, 36-step root and 41-step
// divide loops run and until the result is loaded into the output register;
// the z-score divide is skipped when the deviation is zero.
// Reset: rst_n clears accumulators, reference value and output valid.
// ----------------------------------------------------------------------------
module sample_zscore_stats #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] sample_value
    input  logic        s_axis_tlast,   // last_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [23:0] mean, [46:24] deviation,
                                        // [70:47] z_score, [72:71] status
    input  logic        cfg_wen,
    input  logic [23:0] cfg_wdata       // reference_value
);
    import szs_pkg::*;

    szs_cmd_t  cmd;
    szs_stat_t stat;

    szs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    szs_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/szs_ctrl.sv =====
// ----------------------------------------------------------------------------
// szs_ctrl
// Sequencer: accumulate phase, then multiply, root and divide loops of the
// shared datapath, then hand-off to the output register.
// ----------------------------------------------------------------------------
module szs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    output logic               in_ready,
    input  szs_pkg::szs_stat_t stat,
    output szs_pkg::szs_cmd_t  cmd
);
    import szs_pkg::*;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_MA_INIT = 5'd1;
    localparam logic [4:0] ST_MUL_A   = 5'd2;
    localparam logic [4:0] ST_MB_INIT = 5'd3;
    localparam logic [4:0] ST_MUL_B   = 5'd4;
    localparam logic [4:0] ST_SQ_INIT = 5'd5;
    localparam logic [4:0] ST_SQRT    = 5'd6;
    localparam logic [4:0] ST_DM_INIT = 5'd7;
    localparam logic [4:0] ST_DIV_M   = 5'd8;
    localparam logic [4:0] ST_DD_INIT = 5'd9;
    localparam logic [4:0] ST_DIV_D   = 5'd10;
    localparam logic [4:0] ST_DZ_INIT = 5'd11;
    localparam logic [4:0] ST_DIV_Z   = 5'd12;
    localparam logic [4:0] ST_FIN     = 5'd13;

    logic [4:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = '0;
        in_ready     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.accept   = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && in_last)
                    state_next = ST_MA_INIT;
            end
            ST_MA_INIT:
            begin
                cmd.op     = OP_MA_INIT;
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.op   = OP_MUL;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(MUL_STEPS - 1))
                    state_next = ST_MB_INIT;
            end
            ST_MB_INIT:
            begin
                cmd.op     = OP_MB_INIT;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.op   = OP_MUL;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(MUL_STEPS - 1))
                    state_next = ST_SQ_INIT;
            end
            ST_SQ_INIT:
            begin
                cmd.op     = OP_SQ_INIT;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op   = OP_SQRT;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(SQRT_STEPS - 1))
                    state_next = ST_DM_INIT;
            end
            ST_DM_INIT:
            begin
                cmd.op     = OP_DM_INIT;
                state_next = ST_DIV_M;
            end
            ST_DIV_M:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_DD_INIT;
            end
            ST_DD_INIT:
            begin
                cmd.op     = OP_DD_INIT;
                state_next = ST_DIV_D;
            end
            ST_DIV_D:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_DZ_INIT;
            end
            ST_DZ_INIT:
            begin
                cmd.op     = OP_DZ_INIT;
                // no quotient needed when the deviation is zero
                state_next = stat.dev_zero ? ST_FIN : ST_DIV_Z;
            end
            ST_DIV_Z:
            begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/szs_dp.sv =====
// ----------------------------------------------------------------------------
// szs_dp
// Accumulators, shift-add multiplier, digit-by-digit square root, restoring
// divider and the output register.
// ----------------------------------------------------------------------------
module szs_dp #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  szs_pkg::szs_cmd_t                   cmd,
    output szs_pkg::szs_stat_t                  stat,
    input  logic signed [szs_pkg::SAMPLE_W-1:0] in_sample,
    input  logic                                in_last,
    input  logic                                cfg_wen,
    input  logic signed [szs_pkg::SAMPLE_W-1:0] cfg_wdata,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [szs_pkg::OUT_DATA_W-1:0]      out_data
);
    import szs_pkg::*;

    logic signed [SAMPLE_W-1:0] ref_reg;

    // accumulators
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic                    ovf_reg;

    // captured set
    logic [CNT_W-1:0]        w_cnt_reg;
    logic signed [SUM_W-1:0] w_sum_reg;
    logic [SQ_W-1:0]         w_sq_reg;
    logic                    w_ovf_reg;

    logic [SAMPLE_W-1:0]     in_mag;
    logic [2*SAMPLE_W-1:0]   in_sq;
    logic                    room;
    logic [CNT_W-1:0]        cnt_add;
    logic signed [SUM_W-1:0] sum_add;
    logic [SQ_W-1:0]         sq_add;
    logic [SUM_W-1:0]        sum_mag;

    // multiplier
    logic [WIDE_W-1:0] mp_acc_reg, mp_mcand_reg, a_reg;
    logic [SUM_W-1:0]  mp_mier_reg;

    // square root
    logic [WIDE_W-1:0] sq_op_reg, sq_res_reg, sq_one_reg, sq_trial, diff_ab;

    // divider
    logic [DEV_W-1:0]  dv_rem_reg, dv_den_reg;
    logic [DIVN_W-1:0] dv_quo_reg;
    logic [DEV_W:0]    dv_rem_sh;
    logic              dv_ge;
    logic [DEV_W-1:0]  dev_val;

    logic signed [SAMPLE_W-1:0] mean_reg;
    logic [DEV_W-1:0]           dev_reg;
    logic                       diff_neg_reg, dev_zero_reg;
    logic signed [SAMPLE_W:0]   diff_val;
    logic [SAMPLE_W:0]          diff_mag;
    logic [SAMPLE_W-1:0]        quo_lo;

    // output
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic signed [Z_W-1:0] z_val;
    logic                  z_sat;
    logic [STAT_W-1:0]     stat_val;

    assign in_mag  = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
    assign in_sq   = in_mag * in_mag;
    assign room    = cnt_reg < CNT_W'(MAX_SAMPLES);
    assign cnt_add = room ? cnt_reg + 1'b1 : cnt_reg;
    assign sum_add = room ? sum_reg + SUM_W'(in_sample) : sum_reg;
    assign sq_add  = room ? sq_reg + SQ_W'(in_sq) : sq_reg;

    assign sum_mag = w_sum_reg[SUM_W-1] ? (~w_sum_reg + 1'b1) : w_sum_reg;
    assign diff_ab = (mp_acc_reg <= a_reg) ? (a_reg - mp_acc_reg) : '0;
    assign sq_trial = sq_res_reg + sq_one_reg;

    assign dv_rem_sh = {dv_rem_reg, dv_quo_reg[DIVN_W-1]};
    assign dv_ge     = dv_rem_sh >= {1'b0, dv_den_reg};
    assign quo_lo    = dv_quo_reg[SAMPLE_W-1:0];

    assign dev_val  = (dv_quo_reg > DIVN_W'(DEV_MAX)) ? DEV_MAX : dv_quo_reg[DEV_W-1:0];
    assign diff_val = (SAMPLE_W+1)'(ref_reg) - (SAMPLE_W+1)'(mean_reg);
    assign diff_mag = diff_val[SAMPLE_W] ? (~diff_val + 1'b1) : diff_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= '0;
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
                ref_reg <= cfg_wdata;
            if (cmd.accept)
            begin
                if (in_last)
                begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                    sq_reg  <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_add;
                    sum_reg <= sum_add;
                    sq_reg  <= sq_add;
                    ovf_reg <= ovf_reg | ~room;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_last)
        begin
            w_cnt_reg <= cnt_add;
            w_sum_reg <= sum_add;
            w_sq_reg  <= sq_add;
            w_ovf_reg <= ovf_reg | ~room;
        end
        case (cmd.op)
            OP_MA_INIT:
            begin
                mp_acc_reg   <= '0;
                mp_mcand_reg <= WIDE_W'(w_sq_reg);
                mp_mier_reg  <= SUM_W'(w_cnt_reg);
            end
            OP_MUL:
            begin
                if (mp_mier_reg[0])
                    mp_acc_reg <= mp_acc_reg + mp_mcand_reg;
                mp_mcand_reg <= mp_mcand_reg << 1;
                mp_mier_reg  <= mp_mier_reg >> 1;
            end
            OP_MB_INIT:
            begin
                a_reg        <= mp_acc_reg;
                mp_acc_reg   <= '0;
                mp_mcand_reg <= WIDE_W'(sum_mag);
                mp_mier_reg  <= sum_mag;
            end
            OP_SQ_INIT:
            begin
                sq_op_reg  <= diff_ab;
                sq_res_reg <= '0;
                sq_one_reg <= WIDE_W'(1) << (WIDE_W - 2);
            end
            OP_SQRT:
            begin
                if (sq_op_reg >= sq_trial)
                begin
                    sq_op_reg  <= sq_op_reg - sq_trial;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_one_reg;
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_one_reg <= sq_one_reg >> 2;
            end
            OP_DM_INIT:
            begin
                dv_rem_reg <= '0;
                dv_quo_reg <= DIVN_W'(sum_mag);
                dv_den_reg <= DEV_W'(w_cnt_reg);
            end
            OP_DIV:
            begin
                dv_rem_reg <= dv_ge ? DEV_W'(dv_rem_sh - {1'b0, dv_den_reg})
                                    : dv_rem_sh[DEV_W-1:0];
                dv_quo_reg <= {dv_quo_reg[DIVN_W-2:0], dv_ge};
            end
            OP_DD_INIT:
            begin
                // mean truncates toward zero: divide magnitudes, then sign
                mean_reg   <= w_sum_reg[SUM_W-1] ? (~quo_lo + 1'b1) : quo_lo;
                dv_rem_reg <= '0;
                dv_quo_reg <= DIVN_W'(sq_res_reg[ROOT_W-1:0]);
                dv_den_reg <= DEV_W'(w_cnt_reg);
            end
            OP_DZ_INIT:
            begin
                dev_reg      <= dev_val;
                dev_zero_reg <= (dev_val == '0);
                diff_neg_reg <= diff_val[SAMPLE_W];
                dv_rem_reg   <= '0;
                dv_quo_reg   <= {diff_mag, 16'b0};
                dv_den_reg   <= dev_val;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        z_sat = 1'b0;
        z_val = '0;
        if (!dev_zero_reg)
        begin
            if (diff_neg_reg)
            begin
                z_sat = dv_quo_reg > Z_NEG_LIMIT;
                z_val = z_sat ? Z_W'(~Z_NEG_LIMIT[Z_W-1:0] + 1'b1) : (~quo_lo + 1'b1);
            end
            else
            begin
                z_sat = dv_quo_reg > Z_POS_LIMIT;
                z_val = z_sat ? Z_POS_LIMIT[Z_W-1:0] : quo_lo;
            end
        end
        if (w_ovf_reg)
            stat_val = STAT_CAPACITY;
        else if (dev_zero_reg)
            stat_val = STAT_ZERO_DEV;
        else if (z_sat)
            stat_val = STAT_SAT;
        else
            stat_val = STAT_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= OUT_DATA_W'({stat_val, z_val, dev_reg, mean_reg});
    end

    assign stat.out_free = ~out_valid_reg | out_ready;
    assign stat.dev_zero = (dev_val == '0);
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;

endmodule
